FILE: sv/ptt_pkg.sv
// Shared types and constants for the periodic and one-shot timer slot table.
// Used by the top level, the front stage, the command queue and the back end.
package ptt_pkg;

  localparam int NUM_SLOTS_DEF   = 16;
  localparam int CMD_Q_DEPTH_DEF = 2;
  localparam int FIRED_CAP       = 16;
  localparam int EMIT_W          = 5;

  typedef enum logic [1:0] {
    OP_CREATE_PER = 2'd0,
    OP_CREATE_ONE = 2'd1,
    OP_REMOVE     = 2'd2,
    OP_TICK       = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CREATED    = 3'd0,
    ST_FULL       = 3'd1,
    ST_REMOVED    = 3'd2,
    ST_NOT_ACTIVE = 3'd3,
    ST_FIRED      = 3'd4,
    ST_TICK_DONE  = 3'd5
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] amount;
    logic [63:0] stamp;
    logic [3:0]  target;
  } cmd_t;

  typedef struct packed {
    logic        oneshot;
    logic [31:0] period;
    logic [63:0] due;
    logic [31:0] runs;
  } slot_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  slot_index;
    logic [31:0] runs_so_far;
    logic [4:0]  live_slots;
    logic        last_of_run;
  } res_t;

endpackage

FILE: sv/ptt_in_if.sv
// Input channel of the timer slot table: valid, ready and one command word.
// Stands alone; field widths follow the command format.
interface ptt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] period_or_delay;
  logic [63:0] time_now;
  logic [3:0]  target_slot;

  modport source (output valid, operation, period_or_delay, time_now, target_slot,
                  input ready);
  modport sink (input valid, operation, period_or_delay, time_now, target_slot,
                output ready);
endinterface

FILE: sv/ptt_out_if.sv
// Result channel of the timer slot table: valid, ready and one result word.
// Stands alone; field widths follow the result format.
interface ptt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  slot_index;
  logic [31:0] runs_so_far;
  logic [4:0]  live_slots;
  logic        last_of_run;

  modport source (output valid, status, slot_index, runs_so_far, live_slots, last_of_run,
                  input ready);
  modport sink (input valid, status, slot_index, runs_so_far, live_slots, last_of_run,
                output ready);
endinterface

FILE: sv/periodic_oneshot_timer_table.sv
// Top level of the periodic and one-shot timer slot table.
// Depends on ptt_pkg, ptt_in_if, ptt_out_if, ptt_front, ptt_cmd_q and ptt_back.
//
//   Channel  Direction  Word
//   in_i     sink       operation, period_or_delay, time_now, target_slot
//   out_o    source     status, slot_index, runs_so_far, live_slots, last_of_run
//
// Create and remove each give one result word from the back end.
// A tick scans one slot per cycle, while no fired word waits on a full output, through the
// read port of the slot RAM, then gives the tick-done word.
// Reset clears all active flags at once; slot data is written by each create.
// A result waiting at the output stalls the scan only when it has to emit.
module periodic_oneshot_timer_table #(
  parameter int NUM_SLOTS   = ptt_pkg::NUM_SLOTS_DEF,
  parameter int CMD_Q_DEPTH = ptt_pkg::CMD_Q_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptt_in_if.sink     in_i,
  ptt_out_if.source  out_o
);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  ptt_pkg::cmd_t push_data, pop_data;

  ptt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ptt_cmd_q #(
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  ptt_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_data),
    .out_o       (out_o)
  );

endmodule

FILE: sv/ptt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ptt_front.sv
// Front stage: registers each accepted input word and turns it into a command.
// Depends on ptt_pkg and ptt_in_if; the one-shot due time is added here.
module ptt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  ptt_in_if.sink        in_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output ptt_pkg::cmd_t push_data_o
);

  logic          valid_q, valid_d;
  ptt_pkg::cmd_t cmd_q, cmd_d;
  logic          accept;

  assign in_i.ready = !valid_q || push_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (push_ready_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d       = 1'b1;
      cmd_d.op      = ptt_pkg::op_e'(in_i.operation);
      cmd_d.amount  = in_i.period_or_delay;
      cmd_d.target  = in_i.target_slot;
      if (ptt_pkg::op_e'(in_i.operation) == ptt_pkg::OP_CREATE_ONE) begin
        cmd_d.stamp = in_i.time_now + {32'd0, in_i.period_or_delay};
      end else begin
        cmd_d.stamp = in_i.time_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cmd_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cmd_q   <= cmd_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_data_o  = cmd_q;

endmodule

FILE: sv/ptt_cmd_q.sv
// Short command queue between the front stage and the back end.
// Depends on ptt_pkg for the command word.
module ptt_cmd_q #(
  parameter int DEPTH = ptt_pkg::CMD_Q_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ptt_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ptt_pkg::cmd_t pop_data_o
);

  localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ptt_pkg::cmd_t  slots_q [DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slots_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: sv/ptt_back.sv
// Back end: slot table with active flags, slot RAM, tick scan and result register.
// Depends on ptt_pkg, ptt_out_if and ptt_ram.
module ptt_back #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  ptt_pkg::cmd_t cmd_i,
  ptt_out_if.source     out_o
);

  localparam int IDX_W = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                     state_q, state_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [63:0]                now_q, now_d;
  logic [ptt_pkg::EMIT_W-1:0] emit_q, emit_d;
  logic [NUM_SLOTS-1:0]       active_q, active_d;
  logic [CNT_W-1:0]           total_q, total_d;
  logic                       out_v_q, out_v_d;
  ptt_pkg::res_t              res_q, res_d;

  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  ptt_pkg::slot_t       ram_wdata, rd;
  logic [$bits(ptt_pkg::slot_t)-1:0] ram_rdata;

  logic                 can_emit, load, fire, need_emit, advance, full, in_range;
  logic [NUM_SLOTS-1:0] free_v, low_v;
  logic [IDX_W-1:0]     free_idx, tgt_idx;
  logic [31:0]          idx_w, free_w, total_w;

  ptt_ram #(
    .WIDTH ($bits(ptt_pkg::slot_t)),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd       = ptt_pkg::slot_t'(ram_rdata);
  assign can_emit = !out_v_q || out_o.ready;
  assign full     = &active_q;
  assign free_v   = ~active_q;
  assign low_v    = free_v & (~free_v + NUM_SLOTS'(1));
  assign tgt_idx  = IDX_W'(cmd_i.target);
  assign in_range = {28'd0, cmd_i.target} < 32'(NUM_SLOTS);
  assign idx_w    = 32'(idx_q);
  assign free_w   = 32'(free_idx);

  always_comb begin
    for (int b = 0; b < IDX_W; b++) begin
      free_idx[b] = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (i[b]) begin
          free_idx[b] = free_idx[b] | low_v[i];
        end
      end
    end
  end

  assign fire      = active_q[idx_q] && (now_q >= rd.due);
  assign need_emit = fire && (emit_q < ptt_pkg::EMIT_W'(ptt_pkg::FIRED_CAP));
  assign advance   = !need_emit || can_emit;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    now_d       = now_q;
    emit_d      = emit_q;
    active_d    = active_q;
    total_d     = total_q;
    out_v_d     = out_v_q && !out_o.ready;
    res_d       = res_q;
    load        = 1'b0;
    cmd_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = rd;
    ram_re      = 1'b0;
    ram_raddr   = idx_q + IDX_W'(1);
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && (cmd_i.op == ptt_pkg::OP_TICK || can_emit)) begin
          cmd_ready_o = 1'b1;
          case (cmd_i.op)
            ptt_pkg::OP_CREATE_PER, ptt_pkg::OP_CREATE_ONE: begin
              load              = 1'b1;
              res_d.runs_so_far = '0;
              res_d.last_of_run = 1'b1;
              if (full) begin
                res_d.status     = ptt_pkg::ST_FULL;
                res_d.slot_index = '0;
              end else begin
                ram_we             = 1'b1;
                ram_waddr          = free_idx;
                ram_wdata.oneshot  = cmd_i.op == ptt_pkg::OP_CREATE_ONE;
                ram_wdata.period   = ram_wdata.oneshot ? 32'd0 : cmd_i.amount;
                ram_wdata.due      = ram_wdata.oneshot ? cmd_i.stamp : 64'd0;
                ram_wdata.runs     = '0;
                active_d[free_idx] = 1'b1;
                total_d            = total_q + CNT_W'(1);
                res_d.status       = ptt_pkg::ST_CREATED;
                res_d.slot_index   = free_w[3:0];
              end
            end
            ptt_pkg::OP_REMOVE: begin
              load              = 1'b1;
              res_d.slot_index  = cmd_i.target;
              res_d.runs_so_far = '0;
              res_d.last_of_run = 1'b1;
              if (in_range && active_q[tgt_idx]) begin
                active_d[tgt_idx] = 1'b0;
                total_d           = total_q - CNT_W'(1);
                res_d.status      = ptt_pkg::ST_REMOVED;
              end else begin
                res_d.status = ptt_pkg::ST_NOT_ACTIVE;
              end
            end
            ptt_pkg::OP_TICK: begin
              now_d     = cmd_i.stamp;
              idx_d     = '0;
              emit_d    = '0;
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_d   = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (advance) begin
          if (fire) begin
            ram_we         = 1'b1;
            ram_wdata.runs = rd.runs + 32'd1;
            if (rd.oneshot) begin
              active_d[idx_q] = 1'b0;
              total_d         = total_q - CNT_W'(1);
            end else begin
              ram_wdata.due = now_q + {32'd0, rd.period};
            end
          end
          if (need_emit) begin
            load              = 1'b1;
            emit_d            = emit_q + ptt_pkg::EMIT_W'(1);
            res_d.status      = ptt_pkg::ST_FIRED;
            res_d.slot_index  = idx_w[3:0];
            res_d.runs_so_far = rd.runs + 32'd1;
            res_d.last_of_run = 1'b0;
          end
          if (idx_q == LAST) begin
            state_d = S_DONE;
          end else begin
            ram_re = 1'b1;
            idx_d  = idx_q + IDX_W'(1);
          end
        end
      end
      S_DONE: begin
        if (can_emit) begin
          load              = 1'b1;
          res_d.status      = ptt_pkg::ST_TICK_DONE;
          res_d.slot_index  = '0;
          res_d.runs_so_far = '0;
          res_d.last_of_run = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    total_w = 32'(total_d);
    if (load) begin
      out_v_d          = 1'b1;
      res_d.live_slots = total_w[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      now_q    <= '0;
      emit_q   <= '0;
      active_q <= '0;
      total_q  <= '0;
      out_v_q  <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      now_q    <= now_d;
      emit_q   <= emit_d;
      active_q <= active_d;
      total_q  <= total_d;
      out_v_q  <= out_v_d;
      res_q    <= res_d;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.status      = res_q.status;
  assign out_o.slot_index  = res_q.slot_index;
  assign out_o.runs_so_far = res_q.runs_so_far;
  assign out_o.live_slots  = res_q.live_slots;
  assign out_o.last_of_run = res_q.last_of_run;

  a_total_matches_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(active_q) == int'(total_q))
    else $error("live count differs from the number of active flags");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |-> state_q == S_IDLE)
    else $error("command taken while a tick scan is running");

  a_fired_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q <= ptt_pkg::EMIT_W'(ptt_pkg::FIRED_CAP))
    else $error("more fired words than the result capacity allows");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && idx_q == LAST && advance) |=> state_q == S_DONE)
    else $error("scan past the last slot did not finish the tick");

endmodule

FILE: test/periodic_oneshot_timer_table_tb.sv
// Self-checking testbench for the periodic and one-shot timer slot table.
// Depends on ptt_pkg, ptt_in_if, ptt_out_if and periodic_oneshot_timer_table; a class
// mirrors the slot table and checks every result word in order.
module periodic_oneshot_timer_table_tb;

  localparam int SLOT_COUNT = ptt_pkg::NUM_SLOTS_DEF;

  class timer_slot_mirror;
    bit            live[SLOT_COUNT];
    bit            oneshot[SLOT_COUNT];
    logic [31:0]   interval[SLOT_COUNT];
    logic [63:0]   due_at[SLOT_COUNT];
    logic [31:0]   runs[SLOT_COUNT];
    int unsigned   live_total;
    ptt_pkg::res_t owed_words[$];
    int            errs;

    function void owe(ptt_pkg::status_e st, logic [3:0] idx, logic [31:0] run_cnt,
                      bit last);
      ptt_pkg::res_t r;
      r.status      = st;
      r.slot_index  = idx;
      r.runs_so_far = run_cnt;
      r.live_slots  = 5'(live_total);
      r.last_of_run = last;
      owed_words.push_back(r);
    endfunction

    function void note_command(ptt_pkg::cmd_t c);
      int free_idx;
      int fired;
      free_idx = -1;
      fired = 0;
      case (c.op)
        ptt_pkg::OP_CREATE_PER, ptt_pkg::OP_CREATE_ONE: begin
          for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!live[i]) free_idx = i;
          end
          if (free_idx < 0) begin
            owe(ptt_pkg::ST_FULL, 4'd0, 32'd0, 1'b1);
          end else begin
            live[free_idx] = 1'b1;
            runs[free_idx] = 32'd0;
            oneshot[free_idx] = (c.op == ptt_pkg::OP_CREATE_ONE);
            if (c.op == ptt_pkg::OP_CREATE_PER) begin
              interval[free_idx] = c.amount;
              due_at[free_idx] = 64'd0;
            end else begin
              interval[free_idx] = 32'd0;
              due_at[free_idx] = c.stamp + {32'd0, c.amount};
            end
            live_total++;
            owe(ptt_pkg::ST_CREATED, 4'(free_idx), 32'd0, 1'b1);
          end
        end
        ptt_pkg::OP_REMOVE: begin
          if (int'(c.target) < SLOT_COUNT && live[c.target]) begin
            live[c.target] = 1'b0;
            live_total--;
            owe(ptt_pkg::ST_REMOVED, c.target, 32'd0, 1'b1);
          end else begin
            owe(ptt_pkg::ST_NOT_ACTIVE, c.target, 32'd0, 1'b1);
          end
        end
        default: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (live[i] && c.stamp >= due_at[i]) begin
              runs[i]++;
              if (oneshot[i]) begin
                live[i] = 1'b0;
                live_total--;
              end else begin
                due_at[i] = c.stamp + {32'd0, interval[i]};
              end
              if (fired < ptt_pkg::FIRED_CAP) begin
                owe(ptt_pkg::ST_FIRED, 4'(i), runs[i], 1'b0);
                fired++;
              end
            end
          end
          owe(ptt_pkg::ST_TICK_DONE, 4'd0, 32'd0, 1'b1);
        end
      endcase
    endfunction

    function void check_word(ptt_pkg::res_t got);
      ptt_pkg::res_t want;
      if (owed_words.size() == 0) begin
        $error("unexpected result word: status %0d slot %0d", got.status, got.slot_index);
        errs++;
        return;
      end
      want = owed_words.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, got.status);
        errs++;
      end
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index mismatch: expected %0d, got %0d", want.slot_index, got.slot_index);
        errs++;
      end
      if (got.runs_so_far !== want.runs_so_far) begin
        $error("runs_so_far mismatch: expected %0d, got %0d",
               want.runs_so_far, got.runs_so_far);
        errs++;
      end
      if (got.live_slots !== want.live_slots) begin
        $error("live_slots mismatch: expected %0d, got %0d", want.live_slots, got.live_slots);
        errs++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run mismatch: expected %0d, got %0d",
               want.last_of_run, got.last_of_run);
        errs++;
      end
    endfunction

    function int owed_count();
      return owed_words.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ptt_in_if  in_if ();
  ptt_out_if out_if ();

  periodic_oneshot_timer_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  timer_slot_mirror mirror = new();

  bit          send_burst;
  bit          recv_burst;
  int          mix;
  int          words_taken;
  logic [63:0] now_ticks;

  always #4 clk_i = ~clk_i;

  task automatic send_cmd(input ptt_pkg::op_e op, input logic [31:0] amt,
                          input logic [63:0] stamp, input logic [3:0] tgt);
    ptt_pkg::cmd_t c;
    int            gap;
    c.op = op;
    c.amount = amt;
    c.stamp = stamp;
    c.target = tgt;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.operation       <= c.op;
    in_if.period_or_delay <= c.amount;
    in_if.time_now        <= c.stamp;
    in_if.target_slot     <= c.target;
    do @(posedge clk_i); while (!in_if.ready);
    mirror.note_command(c);
  endtask

  task automatic send_random();
    int          pick;
    int          a;
    int          b;
    int          d;
    ptt_pkg::op_e op;
    logic [31:0] amt;
    logic [63:0] stamp;
    case (mix)
      0: begin a = 40; b = 70; d = 82; end
      1: begin a = 25; b = 45; d = 70; end
      default: begin a = 10; b = 20; d = 55; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < a) op = ptt_pkg::OP_CREATE_PER;
    else if (pick < b) op = ptt_pkg::OP_CREATE_ONE;
    else if (pick < d) op = ptt_pkg::OP_REMOVE;
    else op = ptt_pkg::OP_TICK;
    pick = $urandom_range(0, 9);
    if (pick < 7) amt = $urandom_range(0, 24);
    else if (pick < 9) amt = $urandom;
    else amt = ($urandom_range(0, 1) != 0) ? '1 : '0;
    case (op)
      ptt_pkg::OP_CREATE_ONE: stamp = now_ticks;
      ptt_pkg::OP_TICK: begin
        pick = $urandom_range(0, 24);
        if (pick == 0) begin
          stamp = {$urandom, $urandom};
        end else begin
          if (pick == 1) now_ticks = 64'hFFFF_FFFF_FFFF_FFF0 + 64'($urandom_range(0, 15));
          else now_ticks = now_ticks + 64'($urandom_range(0, 16));
          stamp = now_ticks;
        end
      end
      default: stamp = {$urandom, $urandom};
    endcase
    send_cmd(op, amt, stamp, 4'($urandom_range(0, 15)));
  endtask

  initial begin : stimulus
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = ptt_pkg::OP_TICK;
    in_if.period_or_delay = '0;
    in_if.time_now = '0;
    in_if.target_slot = '0;
    now_ticks = '0;
    send_burst = 1'b0;
    mix = 1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_cmd(ptt_pkg::OP_TICK, 32'd0, 64'd0, 4'd0);
    send_cmd(ptt_pkg::OP_REMOVE, '1, '1, 4'd15);
    send_cmd(ptt_pkg::OP_REMOVE, 32'd0, 64'd0, 4'd0);
    send_cmd(ptt_pkg::OP_CREATE_PER, '1, '1, 4'd9);
    send_cmd(ptt_pkg::OP_CREATE_ONE, '1, '1, 4'd6);
    send_cmd(ptt_pkg::OP_CREATE_ONE, 32'd0, 64'd0, 4'd0);
    for (int k = 0; k < SLOT_COUNT - 3; k++) begin
      send_cmd(ptt_pkg::OP_CREATE_PER, 32'(k), {$urandom, $urandom},
               4'($urandom_range(0, 15)));
    end
    send_cmd(ptt_pkg::OP_CREATE_ONE, 32'd5, 64'd7, 4'd3);
    send_cmd(ptt_pkg::OP_TICK, 32'd0, '1, 4'd0);
    send_cmd(ptt_pkg::OP_TICK, '1, 64'd0, 4'd15);
    send_cmd(ptt_pkg::OP_REMOVE, 32'd0, 64'd0, 4'd0);
    send_cmd(ptt_pkg::OP_REMOVE, 32'd0, 64'd0, 4'd1);
    send_cmd(ptt_pkg::OP_TICK, 32'd0, '1, 4'd0);

    for (int n = 0; n < 460; n++) begin
      if (n % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
      if (n % 50 == 0) mix = $urandom_range(0, 2);
      send_random();
    end
    @(negedge clk_i);
    in_if.valid <= 1'b0;

    while (mirror.owed_count() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mirror.errs == 0) begin
      $display("periodic_oneshot_timer_table_tb: clean");
    end else begin
      $display("periodic_oneshot_timer_table_tb: errors");
    end
    $finish;
  end

  initial begin : word_sink
    int            stall;
    ptt_pkg::res_t got;
    out_if.ready = 1'b0;
    words_taken = 0;
    recv_burst = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (words_taken % 50 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      if (words_taken == 60) stall = 500;
      else stall = recv_burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got.status      = ptt_pkg::status_e'(out_if.status);
      got.slot_index  = out_if.slot_index;
      got.runs_so_far = out_if.runs_so_far;
      got.live_slots  = out_if.live_slots;
      got.last_of_run = out_if.last_of_run;
      words_taken++;
      @(negedge clk_i);
      mirror.check_word(got);
    end
  end

  initial begin : watchdog
    #(8 * 800000);
    $display("periodic_oneshot_timer_table_tb: errors");
    $finish;
  end

endmodule
